// ----- rtl/ece_pkg.sv -----
// easing curve evaluator: shared constants, types and the sine table builder
// no dependencies
package ece_pkg;

    localparam int FRAC_BITS_DEF       = 16;
    localparam int SINE_TABLE_BITS_DEF = 8;
    localparam int ACTION_W            = 5;
    localparam int T_W                 = 17;
    localparam int EASED_W             = 18;
    localparam int ACTION_LAST         = 27;
    localparam int EASED_MAX           = (1 << (EASED_W - 1)) - 1;

    // exp series length and kernel latency (expo path is the longest)
    localparam int EXPO_TERMS     = 12;
    localparam int EXPO_MAX_SHIFT = 10;
    localparam int KERN_LAT       = 3 + 2 * EXPO_TERMS;
    localparam int POLY_STAGES    = 4;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned LN2_Q30     = 64'd744261118;
    localparam longint unsigned BACK_A_Q30  = 64'd2900799437;
    localparam longint unsigned BACK_B_Q30  = 64'd1827057613;

    // curve families in selector order
    localparam logic [3:0] FAM_SINE    = 4'd0;
    localparam logic [3:0] FAM_QUAD    = 4'd1;
    localparam logic [3:0] FAM_CUBE    = 4'd2;
    localparam logic [3:0] FAM_QUINT   = 4'd3;
    localparam logic [3:0] FAM_EXPO    = 4'd4;
    localparam logic [3:0] FAM_BACK    = 4'd5;
    localparam logic [3:0] FAM_BIGBACK = 4'd6;
    localparam logic [3:0] FAM_ELASTIC = 4'd7;
    localparam logic [3:0] FAM_BOUNCE  = 4'd8;

    typedef enum logic [1:0] {
        FORM_IN,
        FORM_OUT,
        FORM_INOUT
    } t_form;

    typedef enum logic [3:0] {
        K_ZERO,
        K_LIN,
        K_SINE,
        K_QUAD,
        K_CUBE,
        K_QUINT,
        K_EXPO,
        K_BACK,
        K_BIGBACK,
        K_EIN,
        K_EOUT,
        K_BOUNCE
    } t_kern;

    typedef enum logic [1:0] {
        P_NONE,
        P_HALF,
        P_HALF_ONE
    } t_post;

    typedef struct packed {
        logic  valid;
        t_kern kern;
        logic  neg;
        t_post post;
    } t_meta;

    // elaboration-time restoring division for the table builder
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // one quarter-wave sine entry, series in q30, evaluated at elaboration
    function automatic longint unsigned sine_entry(input longint unsigned idx, input int fb,
                                                   input int tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint unsigned one_q;
        longint          sum;
        x     = (HALF_PI_Q30 * idx + ((64'd1 << tb) >> 1)) >> tb;
        x2    = (x * x) >> 30;
        term  = x;
        sum   = longint'(x);
        one_q = 64'd1 << fb;
        for (int k = 1; k <= 7; k++) begin
            term = udiv((term * x2) >> 30, longint'(2 * k * (2 * k + 1)));
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (longint'(sum) + (64'd1 << (29 - fb))) >> (30 - fb);
        return (v > one_q) ? one_q : v;
    endfunction

endpackage

// ----- rtl/ece_in_if.sv -----
// input channel of the easing curve evaluator: selector and progress
// depends on ece_pkg
interface ece_in_if;
    import ece_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [T_W-1:0]      t;
    modport source (output valid, action, t, input ready);
    modport sink (input valid, action, t, output ready);
endinterface

// ----- rtl/ece_out_if.sv -----
// output channel of the easing curve evaluator: eased value
// depends on ece_pkg
interface ece_out_if;
    import ece_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [EASED_W-1:0] eased;
    modport source (output valid, eased, input ready);
    modport sink (input valid, eased, output ready);
endinterface

// ----- rtl/ece_front.sv -----
// front stage: clamps progress, decodes selector into kernel, argument and post ops
// depends on ece_pkg
module ece_front #(
    parameter int FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ece_pkg::ACTION_W-1:0]  i_action,
    input  logic [ece_pkg::T_W-1:0]       i_t,
    output ece_pkg::t_meta                o_meta,
    output logic [FRAC_BITS:0]            o_arg
);
    import ece_pkg::*;

    localparam int XW = FRAC_BITS + 1;
    localparam int CW = ((T_W > XW) ? T_W : XW) + 1;
    localparam logic [XW-1:0] ONE   = XW'(1) << FRAC_BITS;
    localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

    t_meta           r_meta;
    t_meta           n_meta;
    logic [XW-1:0]   r_arg;
    logic [XW-1:0]   n_arg;

    logic [CW-1:0]       t_ext;
    logic [XW-1:0]       x;
    logic [XW:0]         x_dbl;
    logic                low;
    logic [XW-1:0]       z;
    logic [4:0]          v;
    logic [8:0]          v11;
    logic [3:0]          fam;
    logic [4:0]          rem;
    t_form               form;
    logic                is_out;
    t_kern               in_kern;

    always_comb begin
        t_ext = CW'(i_t);
        x     = (t_ext > ONE_C) ? ONE : XW'(t_ext);
        x_dbl = {x, 1'b0};
        low   = (x_dbl < (XW + 1)'(ONE));
        // divide by three through a reciprocal, exact for 0..26
        v     = i_action - 5'd1;
        v11   = 9'(v) * 9'd11;
        fam   = v11[8:5];
        rem   = v - 5'(fam) * 5'd3;
        form  = t_form'(rem[1:0]);
        if (form == FORM_INOUT) begin
            z = low ? XW'(x_dbl) : XW'(x_dbl - (XW + 1)'(ONE));
        end else begin
            z = x;
        end
        is_out = (form == FORM_OUT) || ((form == FORM_INOUT) && !low);

        case (fam)
            FAM_SINE:    in_kern = K_SINE;
            FAM_QUAD:    in_kern = K_QUAD;
            FAM_CUBE:    in_kern = K_CUBE;
            FAM_QUINT:   in_kern = K_QUINT;
            FAM_EXPO:    in_kern = K_EXPO;
            FAM_BACK:    in_kern = K_BACK;
            FAM_BIGBACK: in_kern = K_BIGBACK;
            FAM_ELASTIC: in_kern = K_EIN;
            FAM_BOUNCE:  in_kern = K_BOUNCE;
            default:     in_kern = K_ZERO;
        endcase

        n_meta.valid = i_valid;
        n_meta.neg   = 1'b0;
        n_meta.post  = P_NONE;
        n_meta.kern  = K_ZERO;
        n_arg        = x;
        if (i_action == '0) begin
            n_meta.kern = K_LIN;
        end else if (i_action <= ACTION_W'(ACTION_LAST)) begin
            if (form == FORM_INOUT) begin
                n_meta.post = low ? P_HALF : P_HALF_ONE;
            end
            if (!is_out) begin
                // sine and bounce in-curves mirror their direct out-curves
                n_meta.kern = in_kern;
                if ((fam == FAM_SINE) || (fam == FAM_BOUNCE)) begin
                    n_arg      = ONE - z;
                    n_meta.neg = 1'b1;
                end else begin
                    n_arg = z;
                end
            end else if ((fam == FAM_SINE) || (fam == FAM_BOUNCE)) begin
                n_meta.kern = in_kern;
                n_arg       = z;
            end else if (fam == FAM_ELASTIC) begin
                n_meta.kern = K_EOUT;
                n_arg       = z;
            end else begin
                n_meta.kern = in_kern;
                n_arg       = ONE - z;
                n_meta.neg  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta <= '0;
        end else if (i_en) begin
            r_meta <= n_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg <= n_arg;
        end
    end

    assign o_meta = r_meta;
    assign o_arg  = r_arg;

endmodule

// ----- rtl/ece_expo.sv -----
// expo kernel: 2^-(10(1-a)) as shift plus a pipelined exp series on the fraction
// depends on ece_pkg
module ece_expo #(
    parameter int FRAC_BITS = ece_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS:0]   i_arg,
    output logic [FRAC_BITS:0]   o_val
);
    import ece_pkg::*;

    localparam int XW = FRAC_BITS + 1;
    localparam int MW = FRAC_BITS + 4;
    localparam int NT = EXPO_TERMS;
    localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;

    logic [3:0]           r_s1_k;
    logic [FRAC_BITS-1:0] r_s1_r;
    logic [MW-1:0]        m;
    logic [29:0]          rs;
    logic [59:0]          yp;

    logic [30:0]        r_term [0:NT];
    logic signed [32:0] r_sum  [0:NT];
    logic [29:0]        r_y    [0:NT];
    logic [3:0]         r_k    [0:NT];
    logic [29:0]        r_q    [1:NT];
    logic signed [32:0] r_qsum [1:NT];
    logic [29:0]        r_qy   [1:NT];
    logic [3:0]         r_qk   [1:NT];

    logic [XW-1:0]      r_out;
    logic [30:0]        sum_c;
    logic [3:0]         kk;
    logic [5:0]         sh;
    logic [63:0]        rnd;

    always_comb begin
        m  = MW'(10) * MW'(ONE - i_arg);
        rs = 30'(r_s1_r) << (30 - FRAC_BITS);
        yp = 60'(rs) * 60'(LN2_Q30) + (60'(1) << 29);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_k    <= m[MW-1:FRAC_BITS];
            r_s1_r    <= m[FRAC_BITS-1:0];
            r_y[0]    <= 30'(yp >> 30);
            r_k[0]    <= r_s1_k;
            r_term[0] <= 31'(1) << 30;
            r_sum[0]  <= 33'sd1 <<< 30;
        end
    end

    // each term: multiply by y, then exact divide by n through a reciprocal
    for (genvar gn = 1; gn <= NT; gn++) begin : g_term
        localparam int L = $clog2(gn);
        localparam longint unsigned M = ((64'd1 << (30 + L)) + gn - 1) / gn;
        localparam bit ODD = (gn % 2) == 1;
        logic [60:0] w_pa;
        logic [61:0] w_pb;
        logic [30:0] w_tn;
        assign w_pa = 61'(r_term[gn-1]) * 61'(r_y[gn-1]);
        assign w_pb = 62'(r_q[gn]) * 62'(M);
        assign w_tn = 31'(w_pb >> (30 + L));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[gn]    <= 30'(w_pa >> 30);
                r_qsum[gn] <= r_sum[gn-1];
                r_qy[gn]   <= r_y[gn-1];
                r_qk[gn]   <= r_k[gn-1];
                r_term[gn] <= w_tn;
                r_y[gn]    <= r_qy[gn];
                r_k[gn]    <= r_qk[gn];
                if (ODD) begin
                    r_sum[gn] <= r_qsum[gn] - $signed({2'b00, w_tn});
                end else begin
                    r_sum[gn] <= r_qsum[gn] + $signed({2'b00, w_tn});
                end
            end
        end
    end

    always_comb begin
        sum_c = (r_sum[NT] < 0) ? '0 : r_sum[NT][30:0];
        kk    = (r_k[NT] > 4'(EXPO_MAX_SHIFT)) ? 4'(EXPO_MAX_SHIFT) : r_k[NT];
        sh    = 6'(30 - FRAC_BITS) + 6'(kk);
        rnd   = (64'(sum_c) + (64'd1 << (sh - 6'd1))) >> sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= XW'(rnd);
        end
    end

    assign o_val = r_out;

endmodule

// ----- rtl/ece_poly.sv -----
// polynomial kernels: powers, back, elastic, sine table interpolation, bounce
// depends on ece_pkg
module ece_poly #(
    parameter int FRAC_BITS       = ece_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = ece_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  ece_pkg::t_kern               i_kern,
    input  logic [FRAC_BITS:0]           i_arg,
    output logic signed [FRAC_BITS+10:0] o_val
);
    import ece_pkg::*;

    localparam int XW  = FRAC_BITS + 1;
    localparam int KW  = FRAC_BITS + 11;
    localparam int N   = 1 << SINE_TABLE_BITS;
    localparam int IW  = SINE_TABLE_BITS + 1;
    localparam int PW  = 2 * XW + 6;
    localparam int PAD = KERN_LAT - POLY_STAGES;
    localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);
    localparam longint unsigned BC_L =
        ((64'd1 << FRAC_BITS) * BACK_B_Q30 + (64'd1 << 29)) >> 30;
    localparam logic signed [XW+2:0] BC = (XW + 3)'(BC_L);

    logic [XW-1:0] w_rom [0:N];
    for (genvar gi = 0; gi <= N; gi++) begin : g_rom
        localparam longint unsigned V = sine_entry(gi, FRAC_BITS, SINE_TABLE_BITS);
        assign w_rom[gi] = V[XW-1:0];
    end

    // stage a
    t_kern                r_a_kern;
    logic [XW-1:0]        r_a_x, r_a_x2;
    logic [XW+1:0]        r_a_bx;
    logic [IW-1:0]        r_a_si;
    logic [FRAC_BITS-1:0] r_a_sf;
    logic [XW+2:0]        r_a_bm;
    logic [5:0]           r_a_bk;
    logic [PW-1:0]        a_sq;
    logic [XW+31:0]       a_bp;
    logic [XW+SINE_TABLE_BITS-1:0] a_sq_idx;
    logic [XW+3:0]        a_11;
    logic signed [XW+5:0] a_d;
    logic [5:0]           a_c, a_k;

    always_comb begin
        a_sq     = PW'(i_arg) * PW'(i_arg) + RND;
        a_bp     = (XW + 32)'(i_arg) * (XW + 32)'(BACK_A_Q30) + ((XW + 32)'(1) << 29);
        a_sq_idx = (XW + SINE_TABLE_BITS)'(i_arg) << SINE_TABLE_BITS;
        a_11     = (XW + 4)'(i_arg) * (XW + 4)'(11);
        if (a_11 < ((XW + 4)'(4) << FRAC_BITS)) begin
            a_c = 6'd0;
            a_k = 6'd0;
        end else if (a_11 < ((XW + 4)'(8) << FRAC_BITS)) begin
            a_c = 6'd12;
            a_k = 6'd48;
        end else if (a_11 < ((XW + 4)'(10) << FRAC_BITS)) begin
            a_c = 6'd18;
            a_k = 6'd60;
        end else begin
            a_c = 6'd21;
            a_k = 6'd63;
        end
        a_d = $signed((XW + 6)'(i_arg) * (XW + 6)'(22)) -
              $signed((XW + 6)'(a_c) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_kern <= i_kern;
            r_a_x    <= i_arg;
            r_a_x2   <= XW'(a_sq >> FRAC_BITS);
            r_a_bx   <= (XW + 2)'(a_bp >> 30);
            r_a_si   <= a_sq_idx[FRAC_BITS +: IW];
            r_a_sf   <= a_sq_idx[FRAC_BITS-1:0];
            r_a_bm   <= (XW + 3)'((a_d < 0) ? -a_d : a_d);
            r_a_bk   <= a_k;
        end
    end

    // stage b
    t_kern                r_b_kern;
    logic [XW-1:0]        r_b_x, r_b_x2, r_b_x3, r_b_x4;
    logic signed [XW+2:0] r_b_bd, r_b_bbd;
    logic [XW-1:0]        r_b_sa, r_b_sb, r_b_bsq;
    logic [FRAC_BITS-1:0] r_b_sf;
    logic [5:0]           r_b_bk;
    logic [PW-1:0]        b_x3p, b_x4p, b_bsp;
    logic [IW-1:0]        b_hi;

    always_comb begin
        b_x3p = PW'(r_a_x2) * PW'(r_a_x) + RND;
        b_x4p = PW'(r_a_x2) * PW'(r_a_x2) + RND;
        b_bsp = PW'(r_a_bm) * PW'(r_a_bm) + (PW'(1) << (FRAC_BITS + 5));
        b_hi  = (r_a_si == IW'(N)) ? IW'(N) : r_a_si + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_kern <= r_a_kern;
            r_b_x    <= r_a_x;
            r_b_x2   <= r_a_x2;
            r_b_x3   <= XW'(b_x3p >> FRAC_BITS);
            r_b_x4   <= XW'(b_x4p >> FRAC_BITS);
            r_b_bd   <= $signed((XW + 3)'(r_a_bx)) - BC;
            r_b_bbd  <= $signed((XW + 3)'(r_a_x) << 2) - $signed((XW + 3)'(3) << FRAC_BITS);
            r_b_sa   <= w_rom[r_a_si];
            r_b_sb   <= w_rom[b_hi];
            r_b_sf   <= r_a_sf;
            r_b_bsq  <= XW'(b_bsp >> (FRAC_BITS + 6));
            r_b_bk   <= r_a_bk;
        end
    end

    // stage c
    t_kern                r_c_kern;
    logic [XW-1:0]        r_c_x, r_c_x2, r_c_x3, r_c_x4, r_c_x5, r_c_sine;
    logic signed [XW+3:0] r_c_back, r_c_bigback;
    logic [XW:0]          r_c_bounce;
    logic [PW-1:0]        c_x5p, c_bkp, c_bbp, c_sp;
    logic [XW+2:0]        c_bkm, c_bbm;
    logic [XW-1:0]        c_diff;

    always_comb begin
        c_x5p  = PW'(r_b_x4) * PW'(r_b_x) + RND;
        c_bkm  = (XW + 3)'((r_b_bd < 0) ? -r_b_bd : r_b_bd);
        c_bbm  = (XW + 3)'((r_b_bbd < 0) ? -r_b_bbd : r_b_bbd);
        c_bkp  = (PW'(r_b_x2) * PW'(c_bkm) + RND) >> FRAC_BITS;
        c_bbp  = (PW'(r_b_x2) * PW'(c_bbm) + RND) >> FRAC_BITS;
        c_diff = (r_b_sb > r_b_sa) ? r_b_sb - r_b_sa : '0;
        c_sp   = (PW'(c_diff) * PW'(r_b_sf) + RND) >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_kern    <= r_b_kern;
            r_c_x       <= r_b_x;
            r_c_x2      <= r_b_x2;
            r_c_x3      <= r_b_x3;
            r_c_x4      <= r_b_x4;
            r_c_x5      <= XW'(c_x5p >> FRAC_BITS);
            r_c_back    <= (r_b_bd < 0) ? -$signed((XW + 4)'(c_bkp)) : $signed((XW + 4)'(c_bkp));
            r_c_bigback <= (r_b_bbd < 0) ? -$signed((XW + 4)'(c_bbp))
                                         : $signed((XW + 4)'(c_bbp));
            r_c_sine    <= r_b_sa + XW'(c_sp);
            r_c_bounce  <= (XW + 1)'(r_b_bsq) + ((XW + 1)'(r_b_bk) << (FRAC_BITS - 6));
        end
    end

    // stage d: elastic sums and kernel select, then delay to expo latency
    logic signed [KW-1:0] d_x, d_x2, d_x3, d_x4, d_x5, d_ein, d_eout, d_val;
    logic signed [KW-1:0] r_dly [0:PAD];

    always_comb begin
        d_x    = $signed(KW'(r_c_x));
        d_x2   = $signed(KW'(r_c_x2));
        d_x3   = $signed(KW'(r_c_x3));
        d_x4   = $signed(KW'(r_c_x4));
        d_x5   = $signed(KW'(r_c_x5));
        d_ein  = KW'(33) * d_x5 - KW'(59) * d_x4 + KW'(32) * d_x3 - KW'(5) * d_x2;
        d_eout = KW'(33) * d_x5 - KW'(106) * d_x4 + KW'(126) * d_x3 - KW'(67) * d_x2 +
                 KW'(15) * d_x;
        case (r_c_kern)
            K_LIN:     d_val = d_x;
            K_SINE:    d_val = $signed(KW'(r_c_sine));
            K_QUAD:    d_val = d_x2;
            K_CUBE:    d_val = d_x3;
            K_QUINT:   d_val = d_x5;
            K_BACK:    d_val = KW'(r_c_back);
            K_BIGBACK: d_val = KW'(r_c_bigback);
            K_EIN:     d_val = d_ein;
            K_EOUT:    d_val = d_eout;
            K_BOUNCE:  d_val = $signed(KW'(r_c_bounce));
            default:   d_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= d_val;
            for (int i = 1; i <= PAD; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_val = r_dly[PAD];

endmodule

// ----- rtl/easing_curve_evaluator_unit.sv -----
// easing curve evaluator top level: front decode, kernels, post ops, output skid
// depends on ece_pkg, ece_in_if, ece_out_if, ece_front, ece_poly, ece_expo
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------
//   i_in     | in  | action[4:0], t[16:0] (q1.16)    | valid/ready
//   o_out    | out | eased[17:0] signed (q2.16, sat) | valid/ready
//
// one transfer in per cycle while i_in.ready is high, one result per item, in order
// pipeline: front decode, 27 kernel stages set by the 12-term
// expo series (multiply then reciprocal divide per term), two post stages
// i_rst_n clears the control metadata, valid bits and skid flag; no state is kept
// a stall parks the last result in a skid register; the pipeline freezes
// while it is full, so i_in.ready is a flop and nothing is lost or repeated
module easing_curve_evaluator_unit #(
    parameter int FRAC_BITS       = ece_pkg::FRAC_BITS_DEF,
    parameter int SINE_TABLE_BITS = ece_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ece_in_if.sink   i_in,
    ece_out_if.source o_out
);
    import ece_pkg::*;

    localparam int XW = FRAC_BITS + 1;
    localparam int KW = FRAC_BITS + 11;
    localparam logic signed [KW:0] ONE_S  = (KW + 1)'(1) << FRAC_BITS;
    localparam logic signed [KW:0] SAT_HI = (KW + 1)'(EASED_MAX);
    localparam logic signed [KW:0] SAT_LO = (KW + 1)'(-EASED_MAX - 1);

    // global advance: the whole pipe moves unless the skid holds a result
    logic                        en;
    logic                        r_full;
    logic signed [EASED_W-1:0]   r_skid;

    t_meta                       f_meta;
    logic [XW-1:0]               f_arg;
    logic signed [KW-1:0]        poly_val;
    logic [XW-1:0]               expo_val;

    assign en         = !r_full;
    assign i_in.ready = en;

    ece_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_action (i_in.action),
        .i_t      (i_in.t),
        .o_meta   (f_meta),
        .o_arg    (f_arg)
    );

    ece_poly #(
        .FRAC_BITS       (FRAC_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_poly (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_kern (f_meta.kern),
        .i_arg  (f_arg),
        .o_val  (poly_val)
    );

    ece_expo #(
        .FRAC_BITS (FRAC_BITS)
    ) u_expo (
        .i_clk (i_clk),
        .i_en  (en),
        .i_arg (f_arg),
        .o_val (expo_val)
    );

    // control travels beside the kernels with the same depth
    t_meta r_mdly [0:KERN_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KERN_LAT; i++) begin
                r_mdly[i] <= '0;
            end
        end else if (en) begin
            r_mdly[0] <= f_meta;
            for (int i = 1; i < KERN_LAT; i++) begin
                r_mdly[i] <= r_mdly[i-1];
            end
        end
    end

    // post stage one: pick kernel, mirror where neg is set, add one for upper half
    t_meta                k_meta;
    logic signed [KW:0]   kv;
    logic signed [KW:0]   rv;
    logic signed [KW:0]   n_u;
    logic signed [KW:0]   r_u;
    logic                 r_t1_valid;
    t_post                r_t1_post;

    always_comb begin
        k_meta = r_mdly[KERN_LAT-1];
        if (k_meta.kern == K_EXPO) begin
            kv = $signed((KW + 1)'(expo_val));
        end else begin
            kv = (KW + 1)'(poly_val);
        end
        rv  = k_meta.neg ? ONE_S - kv : kv;
        n_u = (k_meta.post == P_HALF_ONE) ? ONE_S + rv : rv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_valid <= 1'b0;
        end else if (en) begin
            r_t1_valid <= k_meta.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_u       <= n_u;
            r_t1_post <= k_meta.post;
        end
    end

    // post stage two: for in-out forms halve with rounding away from zero, then saturate
    logic signed [KW:0]          h;
    logic signed [EASED_W-1:0]   n_eased;
    logic signed [EASED_W-1:0]   r_eased;
    logic                        r_t2_valid;

    always_comb begin
        if (r_t1_post == P_NONE) begin
            h = r_u;
        end else begin
            h = (r_u + $signed((KW + 1)'(!r_u[KW]))) >>> 1;
        end
        if (h > SAT_HI) begin
            n_eased = EASED_W'(SAT_HI);
        end else if (h < SAT_LO) begin
            n_eased = EASED_W'(SAT_LO);
        end else begin
            n_eased = EASED_W'(h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2_valid <= 1'b0;
        end else if (en) begin
            r_t2_valid <= r_t1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_eased <= n_eased;
        end
    end

    // skid: catches the result that leaves the pipe while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (!r_full) begin
            r_full <= r_t2_valid && !o_out.ready;
        end else if (o_out.ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_full) begin
            r_skid <= r_eased;
        end
    end

    assign o_out.valid = r_full || r_t2_valid;
    assign o_out.eased = r_full ? r_skid : r_eased;

endmodule
